[hw/rtl/base64_stream_codec_macros.svh]
// Assertion helpers for the base64 stream codec.
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define B64SC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64 codec: implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define B64SC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64 codec: next-cycle check failed");

`endif

[hw/rtl/b64sc_pkg.sv]
package b64sc_pkg;

    // Result slots in one entry; one input beat causes at most two result beats.
    localparam int B64SC_MAX_RES = 3;
    // Default depth of the queue between front and back.
    localparam int B64SC_QUEUE_DEPTH = 4;

    localparam int RES_IDX_W = $clog2(B64SC_MAX_RES);
    localparam int RES_CNT_W = $clog2(B64SC_MAX_RES + 1);

    // Direction register codes.
    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    // Character classes seen while decoding.
    localparam logic [1:0] CLS_ALPHA = 2'd0;
    localparam logic [1:0] CLS_SKIP  = 2'd1;
    localparam logic [1:0] CLS_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] value;
    } char_class_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       bad_char;
        logic       last;
    } result_t;

    // All results caused by one input beat.
    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        result_t [B64SC_MAX_RES-1:0]   res;
    } entry_t;

    // Maps a character code to its six-bit value, or marks it skipped or invalid.
    function automatic char_class_t b64sc_classify(input logic [7:0] c);
        char_class_t r;
        r.kind  = CLS_BAD;
        r.value = 6'd0;
        if (c == 8'h3d || c == 8'h0a || c == 8'h0d) begin
            r.kind = CLS_SKIP;
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            r.kind  = CLS_ALPHA;
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r.kind  = CLS_ALPHA;
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.kind  = CLS_ALPHA;
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2b) begin
            r.kind  = CLS_ALPHA;
            r.value = 6'd62;
        end else if (c == 8'h2f) begin
            r.kind  = CLS_ALPHA;
            r.value = 6'd63;
        end
        return r;
    endfunction

    // Maps a six-bit value to its alphabet character.
    function automatic logic [7:0] b64sc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'(w + 8'h41);
        end else if (v < 6'd52) begin
            return 8'(w - 8'd26 + 8'h61);
        end else if (v < 6'd62) begin
            return 8'(w - 8'd52 + 8'h30);
        end else if (v == 6'd62) begin
            return 8'h2b;
        end else begin
            return 8'h2f;
        end
    endfunction

endpackage

[hw/rtl/b64sc_front.sv]
module b64sc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             direction,
    input  logic             clear,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_in,
    input  logic             end_of_message,
    input  logic             full,
    output logic             push,
    output b64sc_pkg::entry_t push_data
);
    import b64sc_pkg::*;

    // Only the low six bits of the accumulator are ever needed again.
    logic [5:0]  acc_reg, acc_next;
    // Bit count in units of two bits: 0, 2, 4 or 6 bits held.
    logic [1:0]  cnt_reg, cnt_next;
    logic        err_reg, err_next;

    logic        accept;
    char_class_t cls;
    logic [11:0] dec_acc;
    logic [11:0] enc_acc;
    logic [7:0]  dec_byte;
    entry_t      ent;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign cls      = b64sc_classify(data_in);
    assign dec_acc  = {acc_reg[5:0], cls.value};
    assign enc_acc  = {acc_reg[3:0], data_in};

    // Byte taken from the decode accumulator once eight bits are ready.
    always_comb
    begin
        case (cnt_reg)
            2'd1:    dec_byte = dec_acc[7:0];
            2'd2:    dec_byte = dec_acc[9:2];
            2'd3:    dec_byte = dec_acc[11:4];
            default: dec_byte = 8'd0;
        endcase
    end

    // Build the results of this beat and the next state.
    always_comb
    begin
        ent      = '0;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (direction == DIR_DECODE) begin
            if (!err_reg && cls.kind == CLS_BAD) begin
                ent.count           = RES_CNT_W'(1);
                ent.res[0].bad_char = 1'b1;
                ent.res[0].last     = end_of_message;
                err_next            = 1'b1;
            end else if (!err_reg && cls.kind == CLS_ALPHA) begin
                acc_next = dec_acc[5:0];
                if (cnt_reg != 2'd0) begin
                    ent.count           = RES_CNT_W'(1);
                    ent.res[0].data     = dec_byte;
                    ent.res[0].has_data = 1'b1;
                    ent.res[0].last     = end_of_message;
                    cnt_next            = cnt_reg - 2'd1;
                end else begin
                    cnt_next = 2'd3;
                end
            end
        end else begin
            acc_next = enc_acc[5:0];
            ent.res[0].has_data = 1'b1;
            ent.res[1].has_data = 1'b1;
            case (cnt_reg)
                2'd1:
                begin
                    ent.res[0].data = b64sc_char(enc_acc[9:4]);
                    ent.res[1].data = b64sc_char({enc_acc[3:0], 2'b00});
                    ent.count       = end_of_message ? RES_CNT_W'(2) : RES_CNT_W'(1);
                    ent.res[0].last = 1'b0;
                    ent.res[1].last = end_of_message;
                    cnt_next        = 2'd2;
                end
                2'd2:
                begin
                    ent.res[0].data = b64sc_char(enc_acc[11:6]);
                    ent.res[1].data = b64sc_char(enc_acc[5:0]);
                    ent.count       = RES_CNT_W'(2);
                    ent.res[1].last = end_of_message;
                    cnt_next        = 2'd0;
                end
                default:
                begin
                    ent.res[0].data = b64sc_char(enc_acc[7:2]);
                    ent.res[1].data = b64sc_char({enc_acc[1:0], 4'b0000});
                    ent.count       = end_of_message ? RES_CNT_W'(2) : RES_CNT_W'(1);
                    ent.res[1].last = end_of_message;
                    cnt_next        = 2'd1;
                end
            endcase
            if (ent.count == RES_CNT_W'(1)) begin
                ent.res[0].last = end_of_message;
            end
        end
        // A message end with nothing else to report gives an empty last beat.
        if (end_of_message && ent.count == '0) begin
            ent.count    = RES_CNT_W'(1);
            ent.res[0]   = '0;
            ent.res[0].last = 1'b1;
        end
        if (end_of_message) begin
            acc_next = '0;
            cnt_next = '0;
            err_next = 1'b0;
        end
    end

    assign push      = accept && (ent.count != '0);
    assign push_data = ent;

    // Codec state; a direction write clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end else if (clear) begin
            acc_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end else if (accept) begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

endmodule

[hw/rtl/b64sc_queue.sv]
module b64sc_queue #(
    parameter int DEPTH = b64sc_pkg::B64SC_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64sc_pkg::entry_t push_data,
    input  logic              pop,
    output b64sc_pkg::entry_t head,
    output logic              empty,
    output logic              full
);
    import b64sc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer advance with wrap at the last slot.
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/b64sc_back.sv]
module b64sc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  b64sc_pkg::entry_t head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        data_out,
    output logic              has_data,
    output logic              bad_char,
    output logic              last
);
    import b64sc_pkg::*;

    logic [RES_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;
    logic                 load;
    logic                 final_one;

    // Load the next result beat when the output register is free or being taken.
    assign load      = !empty && (!out_valid_reg || !out_stall);
    assign final_one = (RES_CNT_W'(idx_reg) + 1'b1 == head.count);
    assign pop       = load && final_one;

    // Output register control and index into the head entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            idx_reg       <= final_one ? '0 : idx_reg + 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_res_reg <= head.res[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_res_reg.data;
    assign has_data  = out_res_reg.has_data;
    assign bad_char  = out_res_reg.bad_char;
    assign last      = out_res_reg.last;

endmodule

[hw/rtl/base64_stream_codec.sv]
// Streaming base64 codec.
// Input channel: in_valid / in_stall with data_in and end_of_message; one beat
// is one character (decode) or one byte (encode). Output channel: out_valid /
// out_stall with data_out, has_data, bad_char and last; one beat is one result.
// cfg_write with cfg_data sets the direction (0 decode, 1 encode) and clears
// the codec state; write it only while the block is idle.
// An input beat is written into the result queue, and its results are then
// loaded one by one into the output register. The front takes one input beat
// per cycle while the result queue has room; the back sends one result beat
// per cycle while the receiver does not stall. Decoding therefore runs at one
// character per cycle. An encoded byte gives one or two characters, four for
// every three bytes, so the single output port, not the front, limits the
// input rate in steady flow.
// Reset clears the direction to decode, the accumulator, the queue and the
// output valid flag. When the receiver stalls, the output beat holds, the
// queue fills, and in_stall rises once the queue is full.
`include "base64_stream_codec_macros.svh"

module base64_stream_codec #(
    parameter int QUEUE_DEPTH = b64sc_pkg::B64SC_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_in,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_out,
    output logic       has_data,
    output logic       bad_char,
    output logic       last
);
    import b64sc_pkg::*;

    logic   direction_reg;
    logic   q_push;
    logic   q_pop;
    logic   q_empty;
    logic   q_full;
    entry_t q_in;
    entry_t q_head;

    // Direction register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= DIR_DECODE;
        end else if (cfg_write) begin
            direction_reg <= cfg_data;
        end
    end

    b64sc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .direction      (direction_reg),
        .clear          (cfg_write),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_in        (data_in),
        .end_of_message (end_of_message),
        .full           (q_full),
        .push           (q_push),
        .push_data      (q_in)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    b64sc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .has_data  (has_data),
        .bad_char  (bad_char),
        .last      (last)
    );

    // Checks on the front, queue and result encoding.
    `B64SC_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, q_push, !q_full)
    `B64SC_ASSERT_IMPLY(a_empty_beat_is_last, clk, rst_n, out_valid && !has_data && !bad_char, last)
    `B64SC_ASSERT_IMPLY(a_encode_no_bad, clk, rst_n, out_valid && direction_reg == DIR_ENCODE, !bad_char)
    `B64SC_ASSERT_NEXT(a_pop_frees_slot, clk, rst_n, q_full && q_pop, !q_full)

endmodule
